### rtl/mre_pkg.sv
// Shared constants for the mini RISC instruction executor.
// Depends on nothing; imported by mini_risc_instruction_executor.
package mre_pkg;

    localparam int MEM_WORDS = 256;
    localparam int REG_COUNT = 8;
    localparam int IDX_W     = $clog2(MEM_WORDS);
    localparam int REG_IDX_W = $clog2(REG_COUNT);

    localparam int CMD_W     = 3;
    localparam int ADDR_W    = 8;
    localparam int WORD_W    = 32;
    localparam int INSTR_W   = 16;
    localparam int PC_W      = 9;
    localparam int STATUS_W  = 2;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 144;

    localparam logic [PC_W-1:0] PC_OUT = 9'd256;

    localparam logic [CMD_W-1:0] CMD_LOAD_INSTR = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_DATA  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STEP       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ_DATA  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_REG   = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_HALT    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd3;

    localparam logic [3:0] OP_RTYPE = 4'd0;
    localparam logic [3:0] OP_JUMP  = 4'd2;
    localparam logic [3:0] OP_ADDI  = 4'd4;
    localparam logic [3:0] OP_BEQ   = 4'd8;
    localparam logic [3:0] OP_LW    = 4'd11;
    localparam logic [3:0] OP_SW    = 4'd15;

    localparam logic [2:0] FN_ADD = 3'd0;
    localparam logic [2:0] FN_SUB = 3'd2;
    localparam logic [2:0] FN_AND = 3'd4;
    localparam logic [2:0] FN_OR  = 3'd5;

endpackage

### rtl/mini_risc_instruction_executor.sv
// Top level of the mini RISC instruction executor: sequencer, shared ALU and stores.
// Depends on mre_pkg for widths, command, status and opcode constants.
//
// One request is handled at a time and s_tready is high only while the block waits for
// work. Loads and reads go from fetch straight to the response. A step is taken by the
// sequencer through fetch, register read, one pass of the single shared ALU and the
// single-port data store; a load word step adds a write-back, and a step that halts
// ends after decode. The instruction store reads as zero after reset through one valid
// bit per word, so no clearing pass is needed. A result waiting on m_tready does not
// stop the next request from being accepted.
module mini_risc_instruction_executor (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // address [7:0], value [39:8]
    input  logic [mre_pkg::S_TDATA_W-1:0]  s_tdata,
    // command [2:0]
    input  logic [mre_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status [1:0], next_pc [10:2], read_value [42:11], dest_written [43],
    // dest_index [46:44], dest_value [78:47], narrow_overflow [79],
    // arithmetic_total [111:80], memory_total [143:112]
    output logic [mre_pkg::M_TDATA_W-1:0]  m_tdata
);
    import mre_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FETCH, ST_DECODE, ST_EXEC, ST_MEM, ST_WB, ST_RESP
    } state_t;

    typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_AND, ALU_OR} alu_op_t;

    localparam logic signed [PC_W+1:0] PC_LIMIT = (PC_W+2)'(MEM_WORDS);

    function automatic logic [PC_W-1:0] pc_clip(input logic signed [PC_W+1:0] t);
        if (t < 0 || t >= PC_LIMIT) begin
            return PC_OUT;
        end
        return t[PC_W-1:0];
    endfunction

    state_t state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [WORD_W-1:0]    value_reg, value_next;
    logic [PC_W-1:0]      pc_reg, pc_next;
    logic [WORD_W-1:0]    arith_cnt_reg, arith_cnt_next;
    logic [WORD_W-1:0]    mem_cnt_reg, mem_cnt_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 dw_reg, dw_next;
    logic [REG_IDX_W-1:0] di_reg, di_next;
    logic [WORD_W-1:0]    dv_reg, dv_next;
    logic                 nov_reg, nov_next;
    logic [WORD_W-1:0]    alu_reg, alu_next;
    logic                 instr_ok_reg, instr_ok_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [MEM_WORDS-1:0] imem_valid_reg, imem_valid_next;
    logic [REG_COUNT-1:0] rf_valid_reg, rf_valid_next;

    logic [INSTR_W-1:0] imem [MEM_WORDS];
    logic [WORD_W-1:0]  dmem [MEM_WORDS];
    logic [WORD_W-1:0]  rf   [REG_COUNT];

    logic [INSTR_W-1:0]   imem_rdata_reg;
    logic [WORD_W-1:0]    dmem_rdata_reg;
    logic [WORD_W-1:0]    a_reg, b_reg;

    logic                 imem_we, imem_re, dmem_we, dmem_re, rf_re, rf_we;
    logic [IDX_W-1:0]     imem_addr, dmem_addr;
    logic [WORD_W-1:0]    dmem_wdata, rf_wd;
    logic [REG_IDX_W-1:0] rf_ra, rf_rb, rf_wa;

    logic                 addr_ok, pc_ok, narrow, ea_ok;
    logic [IDX_W-1:0]     mem_idx, pc_idx;
    logic [INSTR_W-1:0]   instr;
    logic [3:0]           op;
    logic [2:0]           fn;
    logic [REG_IDX_W-1:0] rs, rt, rdi;
    logic [5:0]           imm6;
    logic [WORD_W-1:0]    imm32, alu_b, alu_out, rd_value;
    alu_op_t              alu_op;
    logic signed [PC_W+1:0] pc_seq, pc_branch, pc_jump;

    assign addr_ok = 32'(addr_reg) < MEM_WORDS;
    assign pc_ok   = 32'(pc_reg) < MEM_WORDS;
    assign mem_idx = addr_reg[IDX_W-1:0];
    assign pc_idx  = pc_reg[IDX_W-1:0];

    assign instr = instr_ok_reg ? imem_rdata_reg : '0;
    assign op    = instr[15:12];
    assign rs    = instr[11:9];
    assign rt    = instr[8:6];
    assign rdi   = instr[5:3];
    assign fn    = instr[2:0];
    assign imm6  = instr[5:0];
    assign imm32 = {{(WORD_W-6){imm6[5]}}, imm6};

    assign pc_seq    = $signed({2'b00, pc_reg}) + 11'sd1;
    assign pc_branch = pc_seq + $signed({{(PC_W-4){imm6[5]}}, imm6});
    assign pc_jump   = $signed({3'b000, instr[7:0]});

    always_comb begin
        if (op == OP_BEQ || (op == OP_RTYPE && fn == FN_SUB)) begin
            alu_op = ALU_SUB;
        end else if (op == OP_RTYPE && fn == FN_AND) begin
            alu_op = ALU_AND;
        end else if (op == OP_RTYPE && fn == FN_OR) begin
            alu_op = ALU_OR;
        end else begin
            alu_op = ALU_ADD;
        end
        alu_b = (op == OP_RTYPE || op == OP_BEQ) ? b_reg : imm32;
        case (alu_op)
            ALU_SUB: alu_out = a_reg - alu_b;
            ALU_AND: alu_out = a_reg & alu_b;
            ALU_OR:  alu_out = a_reg | alu_b;
            default: alu_out = a_reg + alu_b;
        endcase
    end

    assign narrow = !((&alu_reg[WORD_W-1:7]) || !(|alu_reg[WORD_W-1:7]));
    assign ea_ok  = !alu_reg[WORD_W-1] && (alu_reg < WORD_W'(MEM_WORDS));

    always_comb begin
        if (cmd_reg == CMD_READ_DATA && addr_ok) begin
            rd_value = dmem_rdata_reg;
        end else if (cmd_reg == CMD_READ_REG) begin
            rd_value = a_reg;
        end else begin
            rd_value = '0;
        end
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        value_next      = value_reg;
        pc_next         = pc_reg;
        arith_cnt_next  = arith_cnt_reg;
        mem_cnt_next    = mem_cnt_reg;
        status_next     = status_reg;
        dw_next         = dw_reg;
        di_next         = di_reg;
        dv_next         = dv_reg;
        nov_next        = nov_reg;
        alu_next        = alu_reg;
        instr_ok_next   = instr_ok_reg;
        m_tdata_next    = m_tdata_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        imem_valid_next = imem_valid_reg;
        rf_valid_next   = rf_valid_reg;

        imem_we    = 1'b0;
        imem_re    = 1'b0;
        imem_addr  = mem_idx;
        dmem_we    = 1'b0;
        dmem_re    = 1'b0;
        dmem_addr  = mem_idx;
        dmem_wdata = value_reg;
        rf_re      = 1'b0;
        rf_ra      = addr_reg[REG_IDX_W-1:0];
        rf_rb      = rt;
        rf_we      = 1'b0;
        rf_wa      = rt;
        rf_wd      = alu_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next    = s_tuser[CMD_W-1:0];
                    addr_next   = s_tdata[ADDR_W-1:0];
                    value_next  = s_tdata[ADDR_W+WORD_W-1:ADDR_W];
                    status_next = STAT_DONE;
                    dw_next     = 1'b0;
                    di_next     = '0;
                    dv_next     = '0;
                    nov_next    = 1'b0;
                    state_next  = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_RESP;
                case (cmd_reg)
                    CMD_LOAD_INSTR: begin
                        if (addr_ok) begin
                            imem_we = 1'b1;
                            imem_valid_next[mem_idx] = 1'b1;
                        end else begin
                            status_next = STAT_RANGE;
                        end
                    end
                    CMD_LOAD_DATA: begin
                        if (addr_ok) begin
                            dmem_we = 1'b1;
                        end else begin
                            status_next = STAT_RANGE;
                        end
                    end
                    CMD_READ_DATA: begin
                        if (addr_ok) begin
                            dmem_re = 1'b1;
                        end else begin
                            status_next = STAT_RANGE;
                        end
                    end
                    CMD_READ_REG: begin
                        rf_re = 1'b1;
                    end
                    CMD_STEP: begin
                        imem_re       = 1'b1;
                        imem_addr     = pc_idx;
                        instr_ok_next = pc_ok && imem_valid_reg[pc_idx];
                        state_next    = ST_DECODE;
                    end
                    default: begin
                    end
                endcase
            end
            ST_DECODE: begin
                if (instr == '0) begin
                    status_next = STAT_HALT;
                    state_next  = ST_RESP;
                end else begin
                    rf_re      = 1'b1;
                    rf_ra      = rs;
                    rf_rb      = rt;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                alu_next   = alu_out;
                state_next = ST_MEM;
            end
            ST_MEM: begin
                state_next = ST_RESP;
                pc_next    = pc_clip(pc_seq);
                case (op)
                    OP_RTYPE: begin
                        arith_cnt_next = arith_cnt_reg + 32'd1;
                        if (fn == FN_ADD || fn == FN_SUB || fn == FN_AND || fn == FN_OR) begin
                            rf_we    = 1'b1;
                            rf_wa    = rdi;
                            rf_valid_next[rdi] = 1'b1;
                            dw_next  = 1'b1;
                            di_next  = rdi;
                            dv_next  = alu_reg;
                            nov_next = narrow;
                        end else begin
                            status_next = STAT_INVALID;
                        end
                    end
                    OP_ADDI: begin
                        arith_cnt_next = arith_cnt_reg + 32'd1;
                        rf_we    = 1'b1;
                        rf_valid_next[rt] = 1'b1;
                        dw_next  = 1'b1;
                        di_next  = rt;
                        dv_next  = alu_reg;
                        nov_next = narrow;
                    end
                    OP_JUMP: begin
                        pc_next = pc_clip(pc_jump);
                    end
                    OP_BEQ: begin
                        nov_next = narrow;
                        if (alu_reg == '0) begin
                            pc_next = pc_clip(pc_branch);
                        end
                    end
                    OP_LW, OP_SW: begin
                        nov_next  = narrow;
                        dmem_addr = alu_reg[IDX_W-1:0];
                        if (ea_ok) begin
                            mem_cnt_next = mem_cnt_reg + 32'd1;
                            if (op == OP_LW) begin
                                dmem_re    = 1'b1;
                                state_next = ST_WB;
                            end else begin
                                dmem_we    = 1'b1;
                                dmem_wdata = b_reg;
                            end
                        end else begin
                            status_next = STAT_RANGE;
                        end
                    end
                    default: begin
                        status_next = STAT_INVALID;
                    end
                endcase
            end
            ST_WB: begin
                rf_we   = 1'b1;
                rf_wd   = dmem_rdata_reg;
                rf_valid_next[rt] = 1'b1;
                dw_next = 1'b1;
                di_next = rt;
                dv_next = dmem_rdata_reg;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {mem_cnt_reg, arith_cnt_reg, nov_reg, dv_reg, di_reg,
                                     dw_reg, rd_value, pc_reg, status_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            pc_reg         <= '0;
            arith_cnt_reg  <= '0;
            mem_cnt_reg    <= '0;
            imem_valid_reg <= '0;
            rf_valid_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            m_tvalid_reg   <= m_tvalid_next;
            pc_reg         <= pc_next;
            arith_cnt_reg  <= arith_cnt_next;
            mem_cnt_reg    <= mem_cnt_next;
            imem_valid_reg <= imem_valid_next;
            rf_valid_reg   <= rf_valid_next;
        end
        cmd_reg      <= cmd_next;
        addr_reg     <= addr_next;
        value_reg    <= value_next;
        status_reg   <= status_next;
        dw_reg       <= dw_next;
        di_reg       <= di_next;
        dv_reg       <= dv_next;
        nov_reg      <= nov_next;
        alu_reg      <= alu_next;
        instr_ok_reg <= instr_ok_next;
        m_tdata_reg  <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (imem_we) begin
            imem[imem_addr] <= value_reg[INSTR_W-1:0];
        end
        if (imem_re) begin
            imem_rdata_reg <= imem[imem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (dmem_we) begin
            dmem[dmem_addr] <= dmem_wdata;
        end
        if (dmem_re) begin
            dmem_rdata_reg <= dmem[dmem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf[rf_wa] <= rf_wd;
        end
        if (rf_re) begin
            a_reg <= rf_valid_reg[rf_ra] ? rf[rf_ra] : '0;
            b_reg <= rf_valid_reg[rf_rb] ? rf[rf_rb] : '0;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("A second request was accepted while one was in progress.");

    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg < PC_W'(MEM_WORDS) || pc_reg == PC_OUT)
        else $error("The program counter holds a value outside the store or the marker.");

    a_rf_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        rf_we |-> (state_reg == ST_MEM || state_reg == ST_WB))
        else $error("The register file was written outside the execute phases.");

    a_counters_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |=> $stable(arith_cnt_reg) && $stable(mem_cnt_reg))
        else $error("A counter moved while no instruction was executing.");

    a_dmem_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(dmem_we && dmem_re))
        else $error("The data store was read and written in the same cycle.");

endmodule

### tb/mini_risc_instruction_executor_tb.sv
// Self-checking testbench for mini_risc_instruction_executor: a directed table, then random
// programs built around the current predicted state, with random gaps on both channels.
// Depends on mre_pkg and the executor RTL only.
module mini_risc_instruction_executor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mre_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam int DIRECTED_ROWS = 30;
    localparam int RANDOM_ITEMS  = 900;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [WORD_W-1:0]   mem_total;
        logic [WORD_W-1:0]   arith_total;
        logic                narrow_ovf;
        logic [WORD_W-1:0]   dest_value;
        logic [2:0]          dest_index;
        logic                dest_written;
        logic [WORD_W-1:0]   read_value;
        logic [PC_W-1:0]     next_pc;
        logic [STATUS_W-1:0] status;
    } exec_result_t;

    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [ADDR_W-1:0]   addr;
        logic [WORD_W-1:0]   val;
        bit                  typed;
        logic [STATUS_W-1:0] st;
        logic [PC_W-1:0]     npc;
        logic [WORD_W-1:0]   rdv;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [INSTR_W-1:0] imem [MEM_WORDS] = '{default: '0};
    logic [WORD_W-1:0]  dmem [MEM_WORDS];
    bit                 dmem_ok [MEM_WORDS];
    int                 written_addrs [$];
    logic [WORD_W-1:0]  regs [REG_COUNT] = '{default: '0};
    logic [PC_W-1:0]    pc = '0;
    logic [WORD_W-1:0]  arith_cnt = '0;
    logic [WORD_W-1:0]  mem_cnt = '0;

    exec_result_t pending_results [$];
    int  fail_count = 0;
    int  n_issued = 0;
    int  n_checked = 0;
    int  cycles = 0;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;

    stim_row_t directed_rows [DIRECTED_ROWS];

    mini_risc_instruction_executor uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("mini_risc_instruction_executor_tb NOT OK");
            $finish;
        end
    end

    function automatic bit narrow_out(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] biased;
        biased = v + 32'd128;
        return biased > 32'd255;
    endfunction

    // Works out the result of one request; the state is only updated when commit is set.
    // hole returns the data address a load word would read before it was ever written.
    function automatic exec_result_t predict_exec(input logic [CMD_W-1:0] cmd,
            input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] val, input bit commit,
            output int hole);
        exec_result_t r;
        logic [INSTR_W-1:0] w;
        logic [3:0] op;
        logic [2:0] rs, rt, rd, fn;
        logic [WORD_W-1:0] imm, a, b, alu, st_word;
        longint nxt, ea;
        logic [PC_W-1:0] new_pc;
        logic [WORD_W-1:0] acnt, mcnt;
        bit do_store;
        int st_addr;
        r = '0;
        hole = -1;
        new_pc = pc;
        acnt = arith_cnt;
        mcnt = mem_cnt;
        do_store = 1'b0;
        st_addr = 0;
        st_word = '0;
        case (cmd)
            CMD_LOAD_DATA: begin
                do_store = 1'b1;
                st_addr = int'(addr);
                st_word = val;
            end
            CMD_READ_DATA: r.read_value = dmem[addr];
            CMD_READ_REG:  r.read_value = regs[addr[2:0]];
            CMD_STEP: begin
                w = (pc < MEM_WORDS) ? imem[pc[7:0]] : '0;
                if (w == '0) begin
                    r.status = STAT_HALT;
                end else begin
                    op = w[15:12];
                    rs = w[11:9];
                    rt = w[8:6];
                    rd = w[5:3];
                    fn = w[2:0];
                    imm = {{26{w[5]}}, w[5:0]};
                    a = regs[rs];
                    b = regs[rt];
                    nxt = longint'(pc) + 1;
                    case (op)
                        OP_RTYPE: begin
                            acnt = acnt + 1;
                            case (fn)
                                FN_ADD:  alu = a + b;
                                FN_SUB:  alu = a - b;
                                FN_AND:  alu = a & b;
                                FN_OR:   alu = a | b;
                                default: r.status = STAT_INVALID;
                            endcase
                            if (r.status != STAT_INVALID) begin
                                r.narrow_ovf = narrow_out(alu);
                                r.dest_written = 1'b1;
                                r.dest_index = rd;
                                r.dest_value = alu;
                            end
                        end
                        OP_JUMP: nxt = longint'(w[7:0]);
                        OP_ADDI: begin
                            acnt = acnt + 1;
                            alu = a + imm;
                            r.narrow_ovf = narrow_out(alu);
                            r.dest_written = 1'b1;
                            r.dest_index = rt;
                            r.dest_value = alu;
                        end
                        OP_BEQ: begin
                            alu = a - b;
                            r.narrow_ovf = narrow_out(alu);
                            if (alu == '0) nxt = longint'(pc) + 1 + longint'($signed(imm));
                        end
                        OP_LW, OP_SW: begin
                            alu = a + imm;
                            r.narrow_ovf = narrow_out(alu);
                            ea = longint'($signed(alu));
                            if (ea >= 0 && ea < MEM_WORDS) begin
                                mcnt = mcnt + 1;
                                if (op == OP_LW) begin
                                    if (!dmem_ok[ea]) hole = int'(ea);
                                    r.dest_written = 1'b1;
                                    r.dest_index = rt;
                                    r.dest_value = dmem[ea];
                                end else begin
                                    do_store = 1'b1;
                                    st_addr = int'(ea);
                                    st_word = b;
                                end
                            end else begin
                                r.status = STAT_RANGE;
                            end
                        end
                        default: r.status = STAT_INVALID;
                    endcase
                    new_pc = (nxt < 0 || nxt >= MEM_WORDS) ? PC_OUT : PC_W'(nxt);
                end
            end
            default: ;
        endcase
        if (commit) begin
            if (cmd == CMD_LOAD_INSTR) imem[addr] = val[INSTR_W-1:0];
            if (do_store) begin
                if (!dmem_ok[st_addr]) written_addrs.push_back(st_addr);
                dmem_ok[st_addr] = 1'b1;
                dmem[st_addr] = st_word;
            end
            if (r.dest_written) regs[r.dest_index] = r.dest_value;
            pc = new_pc;
            arith_cnt = acnt;
            mem_cnt = mcnt;
        end
        r.next_pc = new_pc;
        r.arith_total = acnt;
        r.mem_total = mcnt;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] data_word();
        if ($urandom_range(0, 1) == 0) return WORD_W'($urandom_range(0, 300)) - 32'd30;
        return $urandom;
    endfunction

    // Picks an instruction, steering loads and stores towards registers that hold a
    // usable address so that most of them reach the data store.
    function automatic logic [INSTR_W-1:0] make_instr();
        int kind;
        logic [2:0] rs, rt, rd, fn;
        logic [5:0] imm;
        logic [WORD_W-1:0] ea;
        int near_regs [$];
        kind = $urandom_range(0, 99);
        rs = 3'($urandom);
        rt = 3'($urandom);
        rd = 3'($urandom);
        imm = 6'($urandom);
        if (kind < 30) begin
            case ($urandom_range(0, 4))
                0: fn = FN_ADD;
                1: fn = FN_SUB;
                2: fn = FN_AND;
                3: fn = FN_OR;
                default: fn = 3'($urandom);
            endcase
            return {OP_RTYPE, rs, rt, rd, fn};
        end
        if (kind < 45) return {OP_ADDI, rs, rt, imm};
        if (kind < 57) begin
            if ($urandom_range(0, 2) == 0) rt = rs;
            return {OP_BEQ, rs, rt, imm};
        end
        if (kind < 62) return {OP_JUMP, 4'($urandom), 8'($urandom)};
        if (kind < 92) begin
            for (int i = 0; i < REG_COUNT; i++)
                if (regs[i] < MEM_WORDS) near_regs.push_back(i);
            if (near_regs.size() == 0) return {OP_RTYPE, rs, rs, rd, FN_SUB};
            rs = 3'(near_regs[$urandom_range(0, near_regs.size() - 1)]);
            ea = regs[rs] + {{26{imm[5]}}, imm};
            if (ea >= MEM_WORDS) imm = '0;
            return {(kind < 77) ? OP_LW : OP_SW, rs, rt, imm};
        end
        if (kind < 96) return {(kind < 94) ? OP_LW : OP_SW, rs, rt, imm};
        return INSTR_W'($urandom);
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got_v,
            input logic [WORD_W-1:0] want_v);
        $display("result %0d: %0s got %h expected %h", n_checked, what, got_v, want_v);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [WORD_W-1:0] got_v,
            input logic [WORD_W-1:0] want_v);
        if (got_v !== want_v) report_mismatch(what, got_v, want_v);
    endtask

    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
            input logic [WORD_W-1:0] val, input bit typed = 1'b0,
            input logic [STATUS_W-1:0] f_status = STAT_DONE,
            input logic [PC_W-1:0] f_pc = '0, input logic [WORD_W-1:0] f_read = '0);
        exec_result_t want;
        int gap;
        int hole;
        gap = tx_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        want = predict_exec(cmd, addr, val, 1'b1, hole);
        if (typed) begin
            want.status = f_status;
            want.next_pc = f_pc;
            want.read_value = f_read;
        end
        pending_results.push_back(want);
        n_issued++;
        s_tvalid <= 1'b1;
        s_tdata  <= {val, addr};
        s_tuser  <= cmd;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Before a step, fills any data word the step would read unwritten and replaces an
    // instruction that would send the program counter out of range by a jump.
    task automatic run_step(input bit write_first);
        exec_result_t peek;
        int hole;
        if (write_first) issue(CMD_LOAD_INSTR, pc[7:0], {16'($urandom), make_instr()});
        peek = predict_exec(CMD_STEP, '0, '0, 1'b0, hole);
        if (hole >= 0) issue(CMD_LOAD_DATA, ADDR_W'(hole), data_word());
        if (peek.next_pc == PC_OUT)
            issue(CMD_LOAD_INSTR, pc[7:0], {16'($urandom), OP_JUMP, 4'($urandom), 8'($urandom)});
        issue(CMD_STEP, ADDR_W'($urandom), $urandom);
    endtask

    task automatic run_noise();
        logic [CMD_W-1:0] cmd;
        logic [ADDR_W-1:0] addr;
        cmd = CMD_W'($urandom);
        addr = ADDR_W'($urandom);
        if (cmd == CMD_STEP) begin
            run_step(1'b0);
        end else begin
            if (cmd == CMD_READ_DATA && !dmem_ok[addr])
                addr = ADDR_W'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
            issue(cmd, addr, (cmd == CMD_LOAD_DATA) ? data_word() : $urandom);
        end
    endtask

    initial begin
        exec_result_t got, want;
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            gap = rx_steady ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            got = m_tdata;
            n_checked++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request waiting", WORD_W'(got.status), '0);
            end else begin
                want = pending_results.pop_front();
                check_field("status", WORD_W'(got.status), WORD_W'(want.status));
                check_field("next_pc", WORD_W'(got.next_pc), WORD_W'(want.next_pc));
                check_field("read_value", got.read_value, want.read_value);
                check_field("dest_written", WORD_W'(got.dest_written),
                    WORD_W'(want.dest_written));
                check_field("dest_index", WORD_W'(got.dest_index), WORD_W'(want.dest_index));
                check_field("dest_value", got.dest_value, want.dest_value);
                check_field("narrow_overflow", WORD_W'(got.narrow_ovf),
                    WORD_W'(want.narrow_ovf));
                check_field("arithmetic_total", got.arith_total, want.arith_total);
                check_field("memory_total", got.mem_total, want.mem_total);
            end
        end
    end

    initial begin
        int bursts;
        int choice;
        int len;
        directed_rows = '{
            '{CMD_READ_REG,   8'h07, 32'h0000_0000, 1'b1, STAT_DONE,    9'd0,  32'h0},
            '{CMD_STEP,       8'h00, 32'h0000_0000, 1'b1, STAT_HALT,    9'd0,  32'h0},
            '{CMD_UNUSED,     8'hFF, 32'hFFFF_FFFF, 1'b1, STAT_DONE,    9'd0,  32'h0},
            '{CMD_LOAD_DATA,  8'h00, 32'h7FFF_FFFF, 1'b1, STAT_DONE,    9'd0,  32'h0},
            '{CMD_LOAD_DATA,  8'hFF, 32'h8000_0000, 1'b1, STAT_DONE,    9'd0,  32'h0},
            '{CMD_READ_DATA,  8'hFF, 32'h0000_0000, 1'b1, STAT_DONE,    9'd0,  32'h8000_0000},
            '{CMD_LOAD_INSTR, 8'h00, 32'hA5A5_B040, 1'b0, STAT_DONE,    9'd0,  32'h0},
            '{CMD_STEP,       8'h00, 32'h0000_0000, 1'b0, STAT_DONE,    9'd0,  32'h0},
            '{CMD_LOAD_INSTR, 8'h01, 32'h0000_40BF, 1'b0, STAT_DONE,    9'd0,  32'h0},
            '{CMD_STEP,       8'h00, 32'h0000_0000, 1'b0, STAT_DONE,    9'd0,  32'h0},
            '{CMD_LOAD_INSTR, 8'h02, 32'h0000_0258, 1'b0, STAT_DONE,    9'd0,  32'h0},
            '{CMD_STEP,       8'h00, 32'h0000_0000, 1'b0, STAT_DONE,    9'd0,  32'h0},
            '{CMD_LOAD_INSTR, 8'h03, 32'h0000_0462, 1'b0, STAT_DONE,    9'd0,  32'h0},
            '{CMD_STEP,       8'h00, 32'h0000_0000, 1'b0, STAT_DONE,    9'd0,  32'h0},
            '{CMD_LOAD_INSTR, 8'h04, 32'h0000_02AC, 1'b0, STAT_DONE,    9'd0,  32'h0},
            '{CMD_STEP,       8'h00, 32'h0000_0000, 1'b0, STAT_DONE,    9'd0,  32'h0},
            '{CMD_LOAD_INSTR, 8'h05, 32'h0000_00F5, 1'b0, STAT_DONE,    9'd0,  32'h0},
            '{CMD_STEP,       8'h00, 32'h0000_0000, 1'b0, STAT_DONE,    9'd0,  32'h0},
            '{CMD_LOAD_INSTR, 8'h06, 32'h0000_0007, 1'b0, STAT_DONE,    9'd0,  32'h0},
            '{CMD_STEP,       8'h00, 32'h0000_0000, 1'b1, STAT_INVALID, 9'd7,  32'h0},
            '{CMD_LOAD_INSTR, 8'h07, 32'h0000_1000, 1'b0, STAT_DONE,    9'd0,  32'h0},
            '{CMD_STEP,       8'h00, 32'h0000_0000, 1'b1, STAT_INVALID, 9'd8,  32'h0},
            '{CMD_LOAD_INSTR, 8'h08, 32'h0000_F09F, 1'b0, STAT_DONE,    9'd0,  32'h0},
            '{CMD_STEP,       8'h00, 32'h0000_0000, 1'b0, STAT_DONE,    9'd0,  32'h0},
            '{CMD_LOAD_INSTR, 8'h09, 32'h0000_B560, 1'b0, STAT_DONE,    9'd0,  32'h0},
            '{CMD_STEP,       8'h00, 32'h0000_0000, 1'b1, STAT_RANGE,   9'd10, 32'h0},
            '{CMD_LOAD_INSTR, 8'h0A, 32'h0000_2020, 1'b0, STAT_DONE,    9'd0,  32'h0},
            '{CMD_STEP,       8'h00, 32'h0000_0000, 1'b1, STAT_DONE,    9'd32, 32'h0},
            '{CMD_LOAD_INSTR, 8'h20, 32'h0000_8005, 1'b0, STAT_DONE,    9'd0,  32'h0},
            '{CMD_STEP,       8'h00, 32'h0000_0000, 1'b1, STAT_DONE,    9'd38, 32'h0}
        };
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            issue(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].val,
                directed_rows[i].typed, directed_rows[i].st, directed_rows[i].npc,
                directed_rows[i].rdv);

        bursts = 0;
        while (n_issued < DIRECTED_ROWS + RANDOM_ITEMS) begin
            bursts++;
            if (bursts % 6 == 0) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            if (bursts % 20 == 0) wait_until_idle();
            choice = $urandom_range(0, 99);
            len = $urandom_range(2, 12);
            if (choice < 65) begin
                repeat (len) run_step($urandom_range(0, 4) != 0);
            end else if (choice < 80) begin
                for (int k = 1; k <= len && int'(pc) + k < MEM_WORDS; k++)
                    issue(CMD_LOAD_INSTR, ADDR_W'(int'(pc) + k), {16'($urandom), make_instr()});
                repeat (len + 1) run_step(1'b0);
            end else begin
                repeat ($urandom_range(1, 4)) run_noise();
            end
        end

        // A branch taken to a negative target leaves the program counter out of range,
        // after which every step halts; this closes the run.
        wait_until_idle();
        issue(CMD_LOAD_INSTR, pc[7:0], {16'h0000, OP_JUMP, 4'h0, 8'd5});
        issue(CMD_STEP, 8'h00, 32'h0);
        issue(CMD_LOAD_INSTR, 8'd5, {16'h0000, OP_BEQ, 3'd0, 3'd0, 6'h20});
        issue(CMD_STEP, 8'h00, 32'h0, 1'b1, STAT_DONE, PC_OUT, '0);
        issue(CMD_STEP, 8'h00, 32'h0, 1'b1, STAT_HALT, PC_OUT, '0);
        issue(CMD_READ_REG, 8'h03, 32'h0);

        wait_until_idle();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("mini_risc_instruction_executor_tb OK");
        end else begin
            $display("mini_risc_instruction_executor_tb NOT OK");
        end
        $finish;
    end

endmodule

### mini_risc_instruction_executor.f
rtl/mre_pkg.sv
rtl/mini_risc_instruction_executor.sv
tb/mini_risc_instruction_executor_tb.sv
